@@ src/shiftrows_parity_mixcolumns_assert.svh @@
// ----------------------------------------------------------------------------
// shiftrows_parity_mixcolumns assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SHIFTROWS_PARITY_MIXCOLUMNS_ASSERT_SVH
`define SHIFTROWS_PARITY_MIXCOLUMNS_ASSERT_SVH

// Same-cycle implication
`define SPRMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SPRMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sprmc_pkg.sv @@
// ----------------------------------------------------------------------------
// sprmc_pkg
// Byte and column types plus the GF(2^8) helpers used by the column lanes.
// ----------------------------------------------------------------------------
package sprmc_pkg;

    localparam int NUM_ROWS  = 4;
    localparam int NUM_COLS  = 4;
    localparam int HALF_BYTES = 8;

    localparam logic [7:0] GF_REDUCE = 8'h1B;

    typedef logic [7:0] byte_t;
    // one state column, index is the row
    typedef byte_t [NUM_ROWS-1:0] col_t;

    // multiply by x modulo x^8 + x^4 + x^3 + x + 1
    function automatic byte_t xtime(input byte_t x);
        byte_t y;
        y = {x[6:0], 1'b0};
        if (x[7])
        begin
            y = y ^ GF_REDUCE;
        end
        return y;
    endfunction

    // invert the top bit of any byte with odd popcount
    function automatic byte_t parity_flip(input byte_t x);
        return {x[7] ^ (^x), x[6:0]};
    endfunction

endpackage

@@ src/sprmc_lane.sv @@
// ----------------------------------------------------------------------------
// sprmc_lane
// One column lane: parity flip on each byte, then AES MixColumns.
// ----------------------------------------------------------------------------
module sprmc_lane
(
    input  sprmc_pkg::col_t col_in,
    output sprmc_pkg::col_t col_out
);
    import sprmc_pkg::*;

    byte_t s [NUM_ROWS];
    byte_t t [NUM_ROWS];

    // parity-adjusted bytes and their doubles
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            s[r] = parity_flip(col_in[r]);
            t[r] = xtime(s[r]);
        end
    end

    // column matrix 2 3 1 1, rotated per row
    assign col_out[0] = t[0] ^ t[1] ^ s[1] ^ s[2] ^ s[3];
    assign col_out[1] = s[0] ^ t[1] ^ t[2] ^ s[2] ^ s[3];
    assign col_out[2] = s[0] ^ s[1] ^ t[2] ^ t[3] ^ s[3];
    assign col_out[3] = t[0] ^ s[0] ^ s[1] ^ s[2] ^ t[3];

endmodule

@@ src/sprmc_merge.sv @@
// ----------------------------------------------------------------------------
// sprmc_merge
// Packs the four lane columns back into row-major halves and holds the
// result beat in the output register.
// ----------------------------------------------------------------------------
module sprmc_merge
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  sprmc_pkg::col_t              lane_col [sprmc_pkg::NUM_COLS],
    input  logic                         load,
    input  logic                         result_stall,
    output logic                         result_valid,
    output logic                         busy,
    output logic [63:0]                  result_high,
    output logic [63:0]                  result_low
);
    import sprmc_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] high_reg;
    logic [63:0] high_next;
    logic [63:0] low_reg;
    logic [63:0] low_next;

    // row-major packing, byte 4r+c from lane c row r
    always_comb
    begin
        high_next = '0;
        low_next  = '0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                if (r < 2)
                begin
                    high_next[63 - 8 * (4 * r + c) -: 8] = lane_col[c][r];
                end
                else
                begin
                    low_next[63 - 8 * (4 * (r - 2) + c) -: 8] = lane_col[c][r];
                end
            end
        end
    end

    // output register holds while stalled
    assign busy       = valid_reg && result_stall;
    assign valid_next = load || busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_high  = high_reg;
    assign result_low   = low_reg;

endmodule

@@ src/shiftrows_parity_mixcolumns.sv @@
// ----------------------------------------------------------------------------
// shiftrows_parity_mixcolumns
// ShiftRows, per-byte parity flip and AES MixColumns on one 128-bit block.
// ----------------------------------------------------------------------------
// The block takes one 16-byte state per beat and returns one result beat,
// in the same row-major layout, in the cycle after it is taken. It accepts
// a new block every cycle while block_stall is low: four column lanes do
// the parity flip and MixColumns in parallel, and the only register on the
// path is the output register in the merge stage, so block_stall rises
// only while a finished result sits there and result_stall is high.
// ----------------------------------------------------------------------------
module shiftrows_parity_mixcolumns
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        block_valid,
    output logic        block_stall,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    import sprmc_pkg::*;

    byte_t state [NUM_ROWS * NUM_COLS];
    col_t  lane_in  [NUM_COLS];
    col_t  lane_out [NUM_COLS];
    logic  load;
    logic  busy;
    logic  in_zero;
    logic  out_zero;
    logic  out_beat;

    // unpack the two halves into state bytes
    always_comb
    begin
        for (int i = 0; i < HALF_BYTES; i++)
        begin
            state[i]              = block_high[63 - 8 * i -: 8];
            state[HALF_BYTES + i] = block_low[63 - 8 * i -: 8];
        end
    end

    // ShiftRows routing: lane c row r takes byte 4r + ((c + r) mod 4)
    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                lane_in[c][r] = state[NUM_COLS * r + ((c + r) % NUM_COLS)];
            end
        end
    end

    // column lanes
    for (genvar c = 0; c < NUM_COLS; c++)
    begin : g_lane
        sprmc_lane u_lane
        (
            .col_in  (lane_in[c]),
            .col_out (lane_out[c])
        );
    end

    // handshake
    assign block_stall = busy;
    assign load        = block_valid && !busy;

    sprmc_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .lane_col     (lane_out),
        .load         (load),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .busy         (busy),
        .result_high  (result_high),
        .result_low   (result_low)
    );

    // checks
    assign in_zero  = ~|{block_high, block_low};
    assign out_zero = ~|{result_high, result_low};
    assign out_beat = result_valid && !result_stall;

    `include "shiftrows_parity_mixcolumns_assert.svh"

    `SPRMC_ASSERT_NEXT(a_accept_gives_result, load, result_valid, "accepted beat gave no result")
    `SPRMC_ASSERT_NEXT(a_drain_empties, out_beat && !load, !result_valid, "result beat repeated")
    `SPRMC_ASSERT_NEXT(a_zero_block, load && in_zero, out_zero, "zero block gave nonzero result")
    `SPRMC_ASSERT_NOW(a_stall_only_when_full, block_stall, result_valid, "stall with empty output")

endmodule
